### design/mat3inv_pkg.sv
`default_nettype none
package mat3inv_pkg;

  // Default element format is signed Q15.16.
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Depth of the queue between the cofactor front end and the divider back end.
  localparam int QUEUE_DEPTH = 4;

  // Elements are numbered row * 3 + column.
  localparam int NUM_ELEMS = 9;
  localparam int NUM_PRODS = 18;

  // Cofactor j is the product pair (2j) minus (2j+1). Rows of the inverse are
  // the cross products b x c, c x a and a x b of the columns a, b, c.
  localparam int MUL_X [NUM_PRODS] = '{4, 7, 7, 1, 1, 4, 5, 8, 8,
                                       2, 2, 5, 3, 6, 6, 0, 0, 3};
  localparam int MUL_Y [NUM_PRODS] = '{8, 5, 2, 8, 5, 2, 6, 3, 0,
                                       6, 3, 0, 7, 4, 1, 7, 4, 1};

  // The determinant is row 2 of the adjugate dotted with column 2.
  localparam int DET_ELEM [3] = '{2, 5, 8};
  localparam int DET_COF_BASE = 6;

endpackage
`default_nettype wire

### design/mat3inv_front.sv
`default_nettype none
module mat3inv_front #(
  parameter int ELEM_WIDTH = mat3inv_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [ELEM_WIDTH-1:0]           a [mat3inv_pkg::NUM_ELEMS],
  output logic                                   q_push,
  input  logic                                   q_full,
  output logic [9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+1:0] q_data
);
  import mat3inv_pkg::*;

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int CW = 2 * ELEM_WIDTH + 1;
  localparam int DW = 3 * ELEM_WIDTH + 2;

  logic v1, v2, v3, v4;
  logic adv;

  logic signed [PW-1:0]         p    [NUM_PRODS];
  logic signed [ELEM_WIDTH-1:0] e1   [3];
  logic signed [ELEM_WIDTH-1:0] e2   [3];
  logic signed [CW-1:0]         cof2 [NUM_ELEMS];
  logic signed [CW-1:0]         cof3 [NUM_ELEMS];
  logic signed [CW-1:0]         cof4 [NUM_ELEMS];
  logic signed [CW-1:0]         plo  [3];
  logic signed [CW-1:0]         phi  [3];
  logic signed [DW-1:0]         det4;
  logic signed [DW-1:0]         dsum;
  logic signed [DW-1:0]         hx   [3];
  logic signed [DW-1:0]         lx   [3];

  // The whole pipe moves unless the last stage holds a word the queue cannot take.
  assign adv    = !v4 || !q_full;
  assign full   = !adv;
  assign q_push = v4 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    dsum = '0;
    for (int i = 0; i < 3; i++) begin
      hx[i] = DW'(phi[i]);
      lx[i] = DW'(plo[i]);
      dsum  = dsum + (hx[i] <<< ELEM_WIDTH) + lx[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_PRODS; k++) begin
        p[k] <= a[MUL_X[k]] * a[MUL_Y[k]];
      end
      for (int i = 0; i < 3; i++) begin
        e1[i] <= a[DET_ELEM[i]];
        e2[i] <= e1[i];
      end
      for (int j = 0; j < NUM_ELEMS; j++) begin
        cof2[j] <= $signed(p[2*j]) - $signed(p[2*j+1]);
        cof3[j] <= cof2[j];
        cof4[j] <= cof3[j];
      end
      // The cofactor is split in a low unsigned and a high signed half so
      // that each multiplier stays element sized.
      for (int i = 0; i < 3; i++) begin
        plo[i] <= $signed({1'b0, cof2[DET_COF_BASE+i][ELEM_WIDTH-1:0]}) * e2[i];
        phi[i] <= $signed(cof2[DET_COF_BASE+i][CW-1:ELEM_WIDTH]) * e2[i];
      end
      det4 <= dsum;
    end
  end

  always_comb begin
    q_data = '0;
    for (int j = 0; j < NUM_ELEMS; j++) begin
      q_data[j*CW +: CW] = cof4[j];
    end
    q_data[NUM_ELEMS*CW +: DW] = det4;
  end

endmodule
`default_nettype wire

### design/mat3inv_queue.sv
`default_nettype none
module mat3inv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mat3inv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/mat3inv_back.sv
`default_nettype none
module mat3inv_back #(
  parameter int ELEM_WIDTH = mat3inv_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mat3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic [9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+1:0] q_data,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [ELEM_WIDTH-1:0]           inv [mat3inv_pkg::NUM_ELEMS],
  output logic signed [ELEM_WIDTH-1:0]           det_value,
  output logic                                   singular
);
  import mat3inv_pkg::*;

  localparam int CW   = 2 * ELEM_WIDTH + 1;
  localparam int DW   = 3 * ELEM_WIDTH + 2;
  localparam int MW   = 3 * ELEM_WIDTH + 1;
  localparam int RW   = 3 * ELEM_WIDTH + 2;
  localparam int NW   = CW + 2 * FRAC_BITS;
  localparam int QW   = ELEM_WIDTH + 1;
  localparam int CNTW = $clog2(NW);

  localparam logic [QW:0] LIM_POS = {3'b000, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [QW:0] LIM_NEG = LIM_POS + 1'b1;
  localparam logic [MW:0] DHALF   = (MW+1)'(1) << (2 * FRAC_BITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  state_t            state;
  logic [CNTW-1:0]   cnt;
  logic [MW-1:0]     dmag;
  logic              dneg;
  logic              sing;
  logic [NW-1:0]     num   [NUM_ELEMS];
  logic [RW-1:0]     rem   [NUM_ELEMS];
  logic [QW-1:0]     quo   [NUM_ELEMS];
  logic              over  [NUM_ELEMS];
  logic              cneg  [NUM_ELEMS];
  logic              ovalid;

  // Load side.
  logic signed [DW-1:0] dsig;
  logic [DW-1:0]        dabs;
  logic [MW-1:0]        dmag_in;
  logic signed [CW-1:0] csig  [NUM_ELEMS];
  logic [CW-1:0]        cabs  [NUM_ELEMS];

  // One restoring step per lane.
  logic [RW-1:0]        trial     [NUM_ELEMS];
  logic                 ge        [NUM_ELEMS];
  logic [RW-1:0]        rem_next  [NUM_ELEMS];

  // Rounding and saturation.
  logic                 rnd       [NUM_ELEMS];
  logic [QW:0]          qr        [NUM_ELEMS];
  logic [QW:0]          lim       [NUM_ELEMS];
  logic [QW:0]          qsat      [NUM_ELEMS];
  logic [ELEM_WIDTH-1:0] qlow     [NUM_ELEMS];
  logic signed [ELEM_WIDTH-1:0] res [NUM_ELEMS];
  logic [MW:0]          dr;
  logic [MW:0]          dlim;
  logic [MW:0]          dsat;
  logic [ELEM_WIDTH-1:0] dlow;
  logic signed [ELEM_WIDTH-1:0] dres;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign out_empty = !ovalid;

  always_comb begin
    dsig    = q_data[NUM_ELEMS*CW +: DW];
    dabs    = dsig[DW-1] ? DW'(-dsig) : DW'(dsig);
    dmag_in = dabs[MW-1:0];
    for (int j = 0; j < NUM_ELEMS; j++) begin
      csig[j] = q_data[j*CW +: CW];
      cabs[j] = csig[j][CW-1] ? CW'(-csig[j]) : CW'(csig[j]);
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_ELEMS; j++) begin
      trial[j]    = {rem[j][RW-2:0], num[j][NW-1]};
      ge[j]       = trial[j] >= RW'(dmag);
      rem_next[j] = ge[j] ? trial[j] - RW'(dmag) : trial[j];

      rnd[j]  = {rem[j][RW-2:0], 1'b0} >= RW'(dmag);
      qr[j]   = {1'b0, quo[j]} + (QW+1)'(rnd[j]);
      lim[j]  = (cneg[j] ^ dneg) ? LIM_NEG : LIM_POS;
      qsat[j] = (over[j] || (qr[j] > lim[j])) ? lim[j] : qr[j];
      qlow[j] = qsat[j][ELEM_WIDTH-1:0];
      res[j]  = (cneg[j] ^ dneg) ? $signed(-qlow[j]) : $signed(qlow[j]);
    end
    dr   = ({1'b0, dmag} + DHALF) >> (2 * FRAC_BITS);
    dlim = dneg ? (MW+1)'(LIM_NEG) : (MW+1)'(LIM_POS);
    dsat = (dr > dlim) ? dlim : dr;
    dlow = dsat[ELEM_WIDTH-1:0];
    dres = dneg ? $signed(-dlow) : $signed(dlow);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
      cnt    <= '0;
    end else begin
      // In ST_FIN a popped word is replaced directly by the finished one.
      if (ovalid && out_pop && (state != ST_FIN)) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            dmag <= dmag_in;
            dneg <= dsig[DW-1];
            sing <= (dmag_in == '0);
            cnt  <= '0;
            for (int j = 0; j < NUM_ELEMS; j++) begin
              num[j]  <= {cabs[j], {(2*FRAC_BITS){1'b0}}};
              cneg[j] <= csig[j][CW-1];
              rem[j]  <= '0;
              quo[j]  <= '0;
              over[j] <= 1'b0;
            end
            state <= (dmag_in == '0) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          for (int j = 0; j < NUM_ELEMS; j++) begin
            rem[j]  <= rem_next[j];
            num[j]  <= {num[j][NW-2:0], 1'b0};
            quo[j]  <= {quo[j][QW-2:0], ge[j]};
            over[j] <= over[j] | quo[j][QW-1];
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(NW - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!ovalid || out_pop) begin
            ovalid <= 1'b1;
            for (int j = 0; j < NUM_ELEMS; j++) begin
              inv[j] <= sing ? '0 : res[j];
            end
            det_value <= sing ? '0 : dres;
            singular  <= sing;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_run_not_singular: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !sing)
    else $error("divider running on a singular matrix");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (ovalid && singular) |-> (det_value == '0 && inv[0] == '0 && inv[8] == '0))
    else $error("singular result carries nonzero fields");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_RUN || state == ST_FIN))
    else $error("queue word taken without starting work");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && ovalid && !out_pop) |=> (state == ST_FIN && ovalid))
    else $error("finished result lost while output is blocked");

endmodule
`default_nettype wire

### design/matrix3_inverse_top.sv
// Path: the cofactor and determinant pipeline, the queue, then the divider
// back end.
// Throughput is set by the bit-serial restoring divide: the back end takes a
// new word only when idle, and a singular matrix skips the divide.
// Input words are taken back to back while the queue has room.
// Reset: synchronous, active high; it empties the pipeline, queue and output.
`default_nettype none
module matrix3_inverse_top #(
  parameter int ELEM_WIDTH = mat3inv_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mat3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [ELEM_WIDTH-1:0] a00,
  input  logic signed [ELEM_WIDTH-1:0] a01,
  input  logic signed [ELEM_WIDTH-1:0] a02,
  input  logic signed [ELEM_WIDTH-1:0] a10,
  input  logic signed [ELEM_WIDTH-1:0] a11,
  input  logic signed [ELEM_WIDTH-1:0] a12,
  input  logic signed [ELEM_WIDTH-1:0] a20,
  input  logic signed [ELEM_WIDTH-1:0] a21,
  input  logic signed [ELEM_WIDTH-1:0] a22,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [ELEM_WIDTH-1:0] i00,
  output logic signed [ELEM_WIDTH-1:0] i01,
  output logic signed [ELEM_WIDTH-1:0] i02,
  output logic signed [ELEM_WIDTH-1:0] i10,
  output logic signed [ELEM_WIDTH-1:0] i11,
  output logic signed [ELEM_WIDTH-1:0] i12,
  output logic signed [ELEM_WIDTH-1:0] i20,
  output logic signed [ELEM_WIDTH-1:0] i21,
  output logic signed [ELEM_WIDTH-1:0] i22,
  output logic signed [ELEM_WIDTH-1:0] det_value,
  output logic                         singular
);
  import mat3inv_pkg::*;

  // Each queue word holds the nine adjugate entries and the exact determinant.
  localparam int CW   = 2 * ELEM_WIDTH + 1;
  localparam int DW   = 3 * ELEM_WIDTH + 2;
  localparam int ENTW = NUM_ELEMS * CW + DW;

  logic signed [ELEM_WIDTH-1:0] a   [NUM_ELEMS];
  logic signed [ELEM_WIDTH-1:0] inv [NUM_ELEMS];
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_empty;
  logic [ENTW-1:0]              q_din;
  logic [ENTW-1:0]              q_dout;

  assign a[0] = a00;
  assign a[1] = a01;
  assign a[2] = a02;
  assign a[3] = a10;
  assign a[4] = a11;
  assign a[5] = a12;
  assign a[6] = a20;
  assign a[7] = a21;
  assign a[8] = a22;

  // The front end forms the 18 element products, the cofactors and the
  // determinant in a four-stage pipeline that stalls only on a full queue.
  mat3inv_front #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .a      (a),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_din)
  );

  // The queue lets the front end keep accepting words while the back end divides.
  mat3inv_queue #(
    .WIDTH (ENTW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  // The back end runs nine restoring dividers in lockstep against the shared
  // determinant magnitude, rounds to nearest with ties away from zero, and
  // saturates. Its output register holds a finished result while the next
  // word is already being divided.
  mat3inv_back #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_dout),
    .out_empty (empty),
    .out_pop   (pop),
    .inv       (inv),
    .det_value (det_value),
    .singular  (singular)
  );

  assign i00 = inv[0];
  assign i01 = inv[1];
  assign i02 = inv[2];
  assign i10 = inv[3];
  assign i11 = inv[4];
  assign i12 = inv[5];
  assign i20 = inv[6];
  assign i21 = inv[7];
  assign i22 = inv[8];

endmodule
`default_nettype wire

### verif/matrix3_inverse_checker.sv
`timescale 1ns / 100ps
module matrix3_inverse_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  logic [8:0][31:0] a_word,
  input  logic             empty,
  input  logic             pop,
  input  logic [8:0][31:0] i_word,
  input  logic [31:0]      det_value,
  input  logic             singular,
  output int               errors,
  output int               pending,
  output int               checked,
  output int               singular_seen
);

  typedef struct {
    logic [8:0][31:0] inv;
    logic [31:0]      det;
    logic             sing;
  } inverse_t;

  inverse_t inverse_q[$];

  assign pending = inverse_q.size();

  // Rounds |num| / |den| to nearest, ties away from zero, then saturates.
  function automatic logic [31:0] div_round_sat(logic [127:0] num, logic [127:0] den,
                                                bit neg);
    logic [127:0] q;
    logic [127:0] lim;
    q = (2 * num + den) / (2 * den);
    if (q == 0) neg = 0;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic [127:0] mag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Adjugate by cross products of the columns, all at full precision.
  function automatic inverse_t invert(logic [8:0][31:0] a);
    logic signed [127:0] e [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det;
    inverse_t res;
    int u, v, c1, c2;
    for (int k = 0; k < 9; k++) e[k] = signed'(a[k]);
    for (int r = 0; r < 3; r++) begin
      u = (r + 1) % 3;
      v = (r + 2) % 3;
      for (int c = 0; c < 3; c++) begin
        c1 = (c + 1) % 3;
        c2 = (c + 2) % 3;
        adj[r * 3 + c] = e[c1 * 3 + u] * e[c2 * 3 + v] - e[c2 * 3 + u] * e[c1 * 3 + v];
      end
    end
    det = 0;
    for (int r = 0; r < 3; r++) det += adj[6 + r] * e[r * 3 + 2];
    res.sing = (det == 0);
    res.inv = '0;
    res.det = '0;
    if (!res.sing) begin
      res.det = div_round_sat(mag(det), 128'd1 << 32, det < 0);
      for (int k = 0; k < 9; k++)
        res.inv[k] = div_round_sat(mag(adj[k]) << 32, mag(det), (adj[k] < 0) != (det < 0));
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    checked = 0;
    singular_seen = 0;
  end

  always @(posedge clk) begin
    inverse_t want;
    if (!rst) begin
      if (push && !full) inverse_q.push_back(invert(a_word));
      if (pop && !empty) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: result word with nothing outstanding", $realtime);
          errors++;
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (i_word[k] !== want.inv[k])
              report($sformatf("i%0d%0d", k / 3, k % 3), i_word[k], want.inv[k]);
          if (det_value !== want.det) report("det_value", det_value, want.det);
          if (singular !== want.sing) report("singular", singular, want.sing);
          checked++;
          if (want.sing) singular_seen++;
        end
      end
    end
  end

endmodule

### verif/tb_matrix3_inverse_top.sv
`timescale 1ns / 100ps
module tb_matrix3_inverse_top;

  localparam int RANDOM_WORDS = 1430;

  logic             clk;
  logic             rst;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic             singular;
  logic [8:0][31:0] a_word;
  logic [8:0][31:0] i_word;
  logic [31:0]      det_value;
  logic             took_in;
  int               errors, pending, checked, singular_seen;
  int               sent;
  bit               calm_sink;

  matrix3_inverse_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .a00(a_word[0]), .a01(a_word[1]), .a02(a_word[2]),
    .a10(a_word[3]), .a11(a_word[4]), .a12(a_word[5]),
    .a20(a_word[6]), .a21(a_word[7]), .a22(a_word[8]),
    .empty(empty), .pop(pop),
    .i00(i_word[0]), .i01(i_word[1]), .i02(i_word[2]),
    .i10(i_word[3]), .i11(i_word[4]), .i12(i_word[5]),
    .i20(i_word[6]), .i21(i_word[7]), .i22(i_word[8]),
    .det_value(det_value), .singular(singular)
  );

  matrix3_inverse_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .a_word(a_word),
    .empty(empty), .pop(pop), .i_word(i_word), .det_value(det_value),
    .singular(singular), .errors(errors), .pending(pending),
    .checked(checked), .singular_seen(singular_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Remember at each rising edge whether the input word went in, so the
  // driver can read it at the following falling edge without a race.
  always @(posedge clk) took_in <= push && !full;

  // Most gaps are short, a few are long enough to drain the divider.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(4, 1);
    return $urandom_range(250, 20);
  endfunction

  // Drives one matrix at a falling edge and holds it until the block takes it.
  // After acceptance push stays high only if the next word follows at once.
  task automatic send(logic [8:0][31:0] m);
    int gap;
    a_word = m;
    push = 1;
    do @(negedge clk); while (!took_in);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      push = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] fx(int whole);
    return 32'(whole) << 16;
  endfunction

  function automatic logic [8:0][31:0] diag(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
    logic [8:0][31:0] m;
    m = '0;
    m[0] = x;
    m[4] = y;
    m[8] = z;
    return m;
  endfunction

  // Random element: sometimes a full 32-bit pattern, mostly a modest value
  // so the inverse lands inside the Q15.16 range.
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
      2: return 32'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
      default: return 32'($signed($urandom_range(16)) - 8) << 16;
    endcase
  endfunction

  function automatic logic [8:0][31:0] rand_matrix();
    logic [8:0][31:0] m;
    int kind, r, s;
    for (int k = 0; k < 9; k++) m[k] = rand_elem();
    kind = $urandom_range(9);
    if (kind == 0) begin
      // Two equal rows make the determinant exactly zero.
      r = $urandom_range(2);
      s = (r + 1 + $urandom_range(1)) % 3;
      for (int c = 0; c < 3; c++) m[s * 3 + c] = m[r * 3 + c];
    end else if (kind == 1) begin
      // A zero column is singular as well.
      r = $urandom_range(2);
      for (int c = 0; c < 3; c++) m[c * 3 + r] = '0;
    end else if (kind == 2) begin
      // Diagonally dominant, well conditioned.
      for (int k = 0; k < 9; k++)
        m[k] = (k % 4 == 0) ? fx($urandom_range(50, 4)) : 32'(m[k]) >>> 12;
    end
    return m;
  endfunction

  initial begin
    logic [8:0][31:0] m;
    rst = 1;
    push = 0;
    a_word = '0;
    sent = 0;
    repeat (6) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // Directed words: identity, zero, scaled diagonals, extremes of the
    // element range, a rank-deficient integer matrix, a determinant that
    // rounds to zero without being zero, and huge results that saturate.
    send(diag(fx(1), fx(1), fx(1)));
    send('0);
    send(diag(fx(2), fx(-4), fx(8)));
    send(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send(diag(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001));
    send(diag(32'd1, 32'd1, 32'd1));
    send(diag(32'd1, fx(1), fx(1)));
    send(diag(32'd3, 32'd5, fx(-1)));
    send({9{32'hffff_ffff}});
    send({9{32'h8000_0000}});
    send({9{32'h7fff_ffff}});
    send({fx(9), fx(8), fx(7), fx(6), fx(5), fx(4), fx(3), fx(2), fx(1)});
    send({fx(0), fx(1), fx(2), fx(1), fx(0), fx(3), fx(4), fx(-3), fx(8)});
    send({32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333,
          32'hcccc_cccc, 32'h00ff_00ff, 32'hff00_ff00, 32'h1234_5678});
    send({fx(1), fx(2), fx(3), fx(2), fx(4), fx(6), fx(7), fx(1), fx(5)});
    send(diag(fx(-1), fx(-1), fx(-1)));
    send(diag(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    send(diag(fx(1000), fx(1000), fx(1000)));

    // Hold the sender until everything in flight has come out.
    push = 0;
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        push = 0;
        while (pending != 0) @(negedge clk);
      end
      m = rand_matrix();
      send(m);
    end
    push = 0;
  end

  // Result side: pops with random stalls, in stretches of steady popping.
  initial begin
    int stall;
    stall = 0;
    pop = 0;
    calm_sink = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) calm_sink = !calm_sink;
      if (calm_sink) begin
        pop = 1;
      end else if (stall > 0) begin
        pop = 0;
        stall--;
      end else begin
        pop = 1;
        stall = gap_len();
      end
    end
  end

  // Verdict: wait for all words to be accepted and drained, then allow the
  // divider latency for any stray result before judging.
  initial begin
    wait (rst == 0);
    wait (sent == RANDOM_WORDS + 19);
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    $display("Sent %0d matrices, checked %0d inverses, %0d of them singular.",
             sent, checked, singular_seen);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out with %0d words outstanding.", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
